FILE: hdl/ocpmv_pkg.sv
// Shared constants, types and controller encodings for the pair mass veto block.
package ocpmv_pkg;

  // Default sizes handed down from the top level
  localparam int MAX_PARTICLES_DEF = 16;
  localparam int MOMENTUM_BITS_DEF = 24;

  // Fixed field widths
  localparam int CHARGE_W  = 2;
  localparam int ENERGY_W  = 24;
  localparam int THRESH_W  = 24;
  localparam int POS_W     = 4;

  // Threshold after reset, in MeV
  localparam logic [THRESH_W-1:0] THRESH_RESET = 24'd12000;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_EVAL,
    ST_DRAIN,
    ST_EMIT
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_en;
    logic pair_valid;
    logic clear_keep;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic busy;
    logic keep_bit;
  } dp_status_t;

endpackage

FILE: hdl/ocpmv_if.sv
// Valid/ready channel interfaces for particle input and keep-flag output.
interface ocpmv_in_if #(
  parameter int MOMENTUM_BITS = ocpmv_pkg::MOMENTUM_BITS_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic signed [ocpmv_pkg::CHARGE_W-1:0] charge_sign;
  logic        [ocpmv_pkg::ENERGY_W-1:0] energy;
  logic signed [MOMENTUM_BITS-1:0]       mom_x;
  logic signed [MOMENTUM_BITS-1:0]       mom_y;
  logic signed [MOMENTUM_BITS-1:0]       mom_z;
  logic                                  last_in_list;

  modport source (
    output valid, charge_sign, energy, mom_x, mom_y, mom_z, last_in_list,
    input  ready
  );
  modport sink (
    input  valid, charge_sign, energy, mom_x, mom_y, mom_z, last_in_list,
    output ready
  );
endinterface

interface ocpmv_out_if;
  logic                               valid;
  logic                               ready;
  logic                               keep;
  logic [ocpmv_pkg::POS_W-1:0]        position;
  logic                               overflow;
  logic                               final_flag;

  modport source (
    output valid, keep, position, overflow, final_flag,
    input  ready
  );
  modport sink (
    input  valid, keep, position, overflow, final_flag,
    output ready
  );
endinterface

FILE: hdl/ocpmv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ocpmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/ocpmv_datapath.sv
// Particle storage, pipelined pair mass evaluation and keep flags.
module ocpmv_datapath #(
  parameter int MAX_PARTICLES = ocpmv_pkg::MAX_PARTICLES_DEF,
  parameter int MOMENTUM_BITS = ocpmv_pkg::MOMENTUM_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ocpmv_pkg::dp_cmd_t                    cmd,
  output ocpmv_pkg::dp_status_t                 status,
  input  logic [$clog2(MAX_PARTICLES)-1:0]      wr_addr,
  input  logic [$clog2(MAX_PARTICLES)-1:0]      rd_a,
  input  logic [$clog2(MAX_PARTICLES)-1:0]      rd_b,
  input  logic [$clog2(MAX_PARTICLES)-1:0]      emit_idx,
  input  logic signed [ocpmv_pkg::CHARGE_W-1:0] in_charge,
  input  logic [ocpmv_pkg::ENERGY_W-1:0]        in_energy,
  input  logic signed [MOMENTUM_BITS-1:0]       in_px,
  input  logic signed [MOMENTUM_BITS-1:0]       in_py,
  input  logic signed [MOMENTUM_BITS-1:0]       in_pz,
  input  logic                                  cfg_wr_en,
  input  logic [ocpmv_pkg::THRESH_W-1:0]        cfg_wr_data
);

  localparam int AW     = $clog2(MAX_PARTICLES);
  localparam int MB     = MOMENTUM_BITS;
  localparam int EW     = ocpmv_pkg::ENERGY_W;
  localparam int CHW    = ocpmv_pkg::CHARGE_W;
  localparam int TW     = ocpmv_pkg::THRESH_W;
  localparam int WORD_W = CHW + EW + 3 * MB;
  localparam int ES_W   = EW + 1;
  localparam int E2_W   = 2 * ES_W;
  localparam int Q_W    = 2 * MB + 1;
  localparam int SUM_W  = ((2 * MB + 2 > E2_W) ? 2 * MB + 2 : E2_W) + 1;

  // Store both pair members: two copies written alike, read at two places
  logic [WORD_W-1:0] wr_word;
  logic [WORD_W-1:0] word_a;
  logic [WORD_W-1:0] word_b;

  assign wr_word = {in_charge, in_energy, in_px, in_py, in_pz};

  ocpmv_ram #(.WIDTH(WORD_W), .DEPTH(MAX_PARTICLES)) u_ram_a (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_addr (rd_a),
    .rd_data (word_a)
  );

  ocpmv_ram #(.WIDTH(WORD_W), .DEPTH(MAX_PARTICLES)) u_ram_b (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_addr (rd_b),
    .rd_data (word_b)
  );

  // Threshold register and its square
  logic [TW-1:0]   thr_r;
  logic [2*TW-1:0] t2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ocpmv_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
    t2_r <= thr_r * thr_r;
  end

  // Unpack read words
  logic [CHW-1:0]       ch_a, ch_b;
  logic [EW-1:0]        e_a, e_b;
  logic signed [MB-1:0] px_a, px_b, py_a, py_b, pz_a, pz_b;

  assign pz_a = word_a[MB-1:0];
  assign py_a = word_a[2*MB-1:MB];
  assign px_a = word_a[3*MB-1:2*MB];
  assign e_a  = word_a[3*MB+EW-1:3*MB];
  assign ch_a = word_a[WORD_W-1:WORD_W-CHW];
  assign pz_b = word_b[MB-1:0];
  assign py_b = word_b[2*MB-1:MB];
  assign px_b = word_b[3*MB-1:2*MB];
  assign e_b  = word_b[3*MB+EW-1:3*MB];
  assign ch_b = word_b[WORD_W-1:WORD_W-CHW];

  // Stage 1: charge check and component sums
  logic                 neg_a, neg_b, pos_a, pos_b, opp_s1;
  logic [ES_W-1:0]      esum_s1;
  logic signed [MB:0]   sx_s1, sy_s1, sz_s1;

  assign neg_a   = ch_a[CHW-1];
  assign neg_b   = ch_b[CHW-1];
  assign pos_a   = (ch_a == CHW'(1));
  assign pos_b   = (ch_b == CHW'(1));
  assign opp_s1  = (neg_a && pos_b) || (pos_a && neg_b);
  assign esum_s1 = {1'b0, e_a} + {1'b0, e_b};
  assign sx_s1   = {px_a[MB-1], px_a} + {px_b[MB-1], px_b};
  assign sy_s1   = {py_a[MB-1], py_a} + {py_b[MB-1], py_b};
  assign sz_s1   = {pz_a[MB-1], pz_a} + {pz_b[MB-1], pz_b};

  logic               v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0]      ia1_r, ib1_r, ia2_r, ib2_r, ia3_r, ib3_r, ia4_r, ib4_r;
  logic               opp2_r, opp3_r, opp4_r;
  logic [ES_W-1:0]    esum2_r;
  logic signed [MB:0] sx2_r, sy2_r, sz2_r;
  logic [E2_W-1:0]    e2_3_r, e2_4_r;
  logic [Q_W-1:0]     qx3_r, qy3_r, qz3_r;
  logic [SUM_W-1:0]   p2_4_r;

  // Stage 2: squares
  logic [E2_W-1:0]         e2_full;
  logic signed [2*MB+1:0]  qx_full, qy_full, qz_full;

  assign e2_full = esum2_r * esum2_r;
  assign qx_full = sx2_r * sx2_r;
  assign qy_full = sy2_r * sy2_r;
  assign qz_full = sz2_r * sz2_r;

  // Stage 4: veto when the pair mass squared is below threshold squared
  logic [SUM_W-1:0] lhs_s4;
  logic             veto_s4;

  assign lhs_s4  = p2_4_r + SUM_W'(t2_r);
  assign veto_s4 = v4_r && opp4_r && (lhs_s4 > SUM_W'(e2_4_r));

  // Advance pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.pair_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Advance pipeline payload
  always_ff @(posedge clk) begin
    ia1_r   <= rd_a;
    ib1_r   <= rd_b;
    ia2_r   <= ia1_r;
    ib2_r   <= ib1_r;
    opp2_r  <= opp_s1;
    esum2_r <= esum_s1;
    sx2_r   <= sx_s1;
    sy2_r   <= sy_s1;
    sz2_r   <= sz_s1;
    ia3_r   <= ia2_r;
    ib3_r   <= ib2_r;
    opp3_r  <= opp2_r;
    e2_3_r  <= e2_full;
    qx3_r   <= qx_full[Q_W-1:0];
    qy3_r   <= qy_full[Q_W-1:0];
    qz3_r   <= qz_full[Q_W-1:0];
    ia4_r   <= ia3_r;
    ib4_r   <= ib3_r;
    opp4_r  <= opp3_r;
    e2_4_r  <= e2_3_r;
    p2_4_r  <= SUM_W'(qx3_r) + SUM_W'(qy3_r) + SUM_W'(qz3_r);
  end

  // Keep flags: set all at reset and once the last flag is emitted, drop both members of a vetoed pair
  logic [MAX_PARTICLES-1:0] keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_keep) begin
      keep_r <= '1;
    end else if (veto_s4) begin
      keep_r[ia4_r] <= 1'b0;
      keep_r[ib4_r] <= 1'b0;
    end
  end

  assign status.busy     = v1_r || v2_r || v3_r || v4_r;
  assign status.keep_bit = keep_r[emit_idx];

endmodule

FILE: hdl/ocpmv_ctrl.sv
// Controller: list loading, pair sequencing, drain and result output register.
module ocpmv_ctrl #(
  parameter int MAX_PARTICLES = ocpmv_pkg::MAX_PARTICLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_last,
  output logic                             in_ready,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_keep,
  output logic [ocpmv_pkg::POS_W-1:0]      out_position,
  output logic                             out_overflow,
  output logic                             out_final_flag,
  output ocpmv_pkg::dp_cmd_t               cmd,
  input  ocpmv_pkg::dp_status_t            status,
  output logic [$clog2(MAX_PARTICLES)-1:0] wr_addr,
  output logic [$clog2(MAX_PARTICLES)-1:0] rd_a,
  output logic [$clog2(MAX_PARTICLES)-1:0] rd_b,
  output logic [$clog2(MAX_PARTICLES)-1:0] emit_idx
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int PW = ocpmv_pkg::POS_W;

  ocpmv_pkg::ctrl_state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_keep_r, out_ovf_r, out_final_r;
  logic [PW-1:0] out_pos_r;

  logic          accept, room, row_end, last_pair, slot_free, emit_last, emit_load;
  logic [CW-1:0] cnt_load;

  assign accept    = in_valid && (state_r == ocpmv_pkg::ST_LOAD);
  assign room      = (cnt_r < CW'(MAX_PARTICLES));
  assign cnt_load  = room ? (cnt_r + CW'(1)) : cnt_r;
  assign row_end   = (j_r == (i_r - AW'(1)));
  assign last_pair = row_end && ((CW'(i_r) + CW'(1)) == cnt_r);
  assign slot_free = !out_valid_r || out_ready;
  assign emit_last = ((CW'(k_r) + CW'(1)) == cnt_r);
  assign emit_load = (state_r == ocpmv_pkg::ST_EMIT) && slot_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ocpmv_pkg::ST_LOAD: begin
        if (accept && in_last) begin
          state_nxt = (cnt_load >= CW'(2)) ? ocpmv_pkg::ST_EVAL : ocpmv_pkg::ST_DRAIN;
        end
      end
      ocpmv_pkg::ST_EVAL: begin
        if (last_pair) begin
          state_nxt = ocpmv_pkg::ST_DRAIN;
        end
      end
      ocpmv_pkg::ST_DRAIN: begin
        if (!status.busy) begin
          state_nxt = ocpmv_pkg::ST_EMIT;
        end
      end
      ocpmv_pkg::ST_EMIT: begin
        if (slot_free && emit_last) begin
          state_nxt = ocpmv_pkg::ST_LOAD;
        end
      end
      default: state_nxt = ocpmv_pkg::ST_LOAD;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd.wr_en      = 1'b0;
    cmd.pair_valid = 1'b0;
    cmd.clear_keep = 1'b0;
    in_ready       = 1'b0;
    unique case (state_r)
      ocpmv_pkg::ST_LOAD: begin
        in_ready  = 1'b1;
        cmd.wr_en = accept && room;
      end
      ocpmv_pkg::ST_EVAL: begin
        cmd.pair_valid = 1'b1;
      end
      ocpmv_pkg::ST_DRAIN: begin
        cmd.pair_valid = 1'b0;
      end
      ocpmv_pkg::ST_EMIT: begin
        cmd.clear_keep = slot_free && emit_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign wr_addr  = cnt_r[AW-1:0];
  assign rd_a     = i_r;
  assign rd_b     = j_r;
  assign emit_idx = k_r;

  // Counters and list status
  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    k_nxt   = k_r;
    if (accept) begin
      cnt_nxt = cnt_load;
      if (!room) begin
        ovf_nxt = 1'b1;
      end
      i_nxt = AW'(1);
      j_nxt = '0;
      k_nxt = '0;
    end
    if (state_r == ocpmv_pkg::ST_EVAL) begin
      if (row_end) begin
        i_nxt = i_r + AW'(1);
        j_nxt = '0;
      end else begin
        j_nxt = j_r + AW'(1);
      end
    end
    if (emit_load) begin
      k_nxt = k_r + AW'(1);
      if (emit_last) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
    end
  end

  // Output register: load when empty or being taken, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ocpmv_pkg::ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold output payload until the next load
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_keep_r  <= status.keep_bit;
      out_pos_r   <= PW'(k_r);
      out_ovf_r   <= ovf_r;
      out_final_r <= emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_keep       = out_keep_r;
  assign out_position   = out_pos_r;
  assign out_overflow   = out_ovf_r;
  assign out_final_flag = out_final_r;

endmodule

FILE: hdl/opposite_charge_pair_mass_veto_core.sv
// Top level of the opposite-charge low-mass pair veto.
//
// Usage: particles of one same-flavor list enter on in_ch, one per
// transaction; the transaction with last_in_list set closes the list.
// in_ch stays ready throughout loading. The list holds up to
// MAX_PARTICLES entries; further particles are ignored and the list is
// reported with overflow set. After the last particle, every pair is
// evaluated through the pair pipeline at one pair per cycle; then one
// keep flag per particle leaves on out_ch in load order, one per cycle
// when the receiver is ready, the final one marked by final_flag. For a
// full list the single pair pipeline sets the pace. in_ch is not ready
// during evaluation and output.
// cfg_wr_en/cfg_wr_data set the mass threshold in MeV; write it while idle.
// Reset: threshold 12000 MeV, empty list, no result pending; no clearing
// pass is needed. A stalled receiver holds the result in the output
// register and pauses the output sequence; loading of the next list begins
// as soon as the last flag sits in that register.
module opposite_charge_pair_mass_veto_core #(
  parameter int MAX_PARTICLES = ocpmv_pkg::MAX_PARTICLES_DEF,
  parameter int MOMENTUM_BITS = ocpmv_pkg::MOMENTUM_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ocpmv_in_if.sink                         in_ch,
  ocpmv_out_if.source                      out_ch,
  input  logic                             cfg_wr_en,
  input  logic [ocpmv_pkg::THRESH_W-1:0]   cfg_wr_data
);

  localparam int AW = $clog2(MAX_PARTICLES);

  ocpmv_pkg::dp_cmd_t    cmd;
  ocpmv_pkg::dp_status_t status;
  logic [AW-1:0]         wr_addr, rd_a, rd_b, emit_idx;

  ocpmv_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_last        (in_ch.last_in_list),
    .in_ready       (in_ch.ready),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_keep       (out_ch.keep),
    .out_position   (out_ch.position),
    .out_overflow   (out_ch.overflow),
    .out_final_flag (out_ch.final_flag),
    .cmd            (cmd),
    .status         (status),
    .wr_addr        (wr_addr),
    .rd_a           (rd_a),
    .rd_b           (rd_b),
    .emit_idx       (emit_idx)
  );

  ocpmv_datapath #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .MOMENTUM_BITS (MOMENTUM_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .wr_addr     (wr_addr),
    .rd_a        (rd_a),
    .rd_b        (rd_b),
    .emit_idx    (emit_idx),
    .in_charge   (in_ch.charge_sign),
    .in_energy   (in_ch.energy),
    .in_px       (in_ch.mom_x),
    .in_py       (in_ch.mom_y),
    .in_pz       (in_ch.mom_z),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

FILE: test/ocpmv_keep_flag_checker.sv
// Keep-flag checker for the pair mass veto: predicts flags from accepted particles, checks output.
`timescale 1ns / 1ps

module ocpmv_keep_flag_checker #(
  parameter int MAX_PARTICLES = ocpmv_pkg::MAX_PARTICLES_DEF,
  parameter int MOMENTUM_BITS = ocpmv_pkg::MOMENTUM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ocpmv_in_if                            in_ch,
  ocpmv_out_if                           out_ch,
  input  logic                           cfg_wr_en,
  input  logic [ocpmv_pkg::THRESH_W-1:0] cfg_wr_data,
  output int                             mismatch_count,
  output int                             flags_pending
);

  localparam int CHARGE_W = ocpmv_pkg::CHARGE_W;
  localparam int ENERGY_W = ocpmv_pkg::ENERGY_W;
  localparam int POS_W    = ocpmv_pkg::POS_W;
  localparam int THRESH_W = ocpmv_pkg::THRESH_W;
  localparam logic [THRESH_W-1:0] THRESH_RESET = ocpmv_pkg::THRESH_RESET;

  typedef struct {
    logic signed [CHARGE_W-1:0]      charge;
    logic        [ENERGY_W-1:0]      energy;
    logic signed [MOMENTUM_BITS-1:0] px;
    logic signed [MOMENTUM_BITS-1:0] py;
    logic signed [MOMENTUM_BITS-1:0] pz;
  } particle_t;

  typedef struct packed {
    logic             keep;
    logic [POS_W-1:0] position;
    logic             overflow;
    logic             final_flag;
  } keep_flag_t;

  particle_t           list_slots [MAX_PARTICLES];
  int                  list_len;
  logic                list_overflow;
  logic [THRESH_W-1:0] mass_threshold;
  keep_flag_t          flags_due [$];

  bit         keep_vec [MAX_PARTICLES];
  longint     esum, e_sq, p_sq, thresh_sq;
  keep_flag_t flag_got, flag_want;

  // Square of a summed momentum component, both sign-extended to 64 bits
  function automatic longint sum_sq(longint a, longint b);
    return (a + b) * (a + b);
  endfunction

  task automatic log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      list_len       = 0;
      list_overflow  = 1'b0;
      mass_threshold = THRESH_RESET;
      flags_due.delete();
    end else begin
      // Track threshold writes
      if (cfg_wr_en) begin
        mass_threshold = cfg_wr_data;
      end

      // Load an accepted particle, or note the overflow
      if (in_ch.valid && in_ch.ready) begin
        if (list_len < MAX_PARTICLES) begin
          list_slots[list_len] = '{in_ch.charge_sign, in_ch.energy,
                                   in_ch.mom_x, in_ch.mom_y, in_ch.mom_z};
          list_len++;
        end else begin
          list_overflow = 1'b1;
        end

        // Close the list: veto low-mass opposite-charge pairs, queue one flag per slot
        if (in_ch.last_in_list) begin
          thresh_sq = longint'(mass_threshold) * longint'(mass_threshold);
          foreach (keep_vec[k]) keep_vec[k] = 1'b1;
          for (int i = 1; i < list_len; i++) begin
            for (int j = 0; j < i; j++) begin
              if ((list_slots[i].charge < 0 && list_slots[j].charge > 0) ||
                  (list_slots[i].charge > 0 && list_slots[j].charge < 0)) begin
                esum = longint'(list_slots[i].energy) + longint'(list_slots[j].energy);
                e_sq = esum * esum;
                p_sq = sum_sq(list_slots[i].px, list_slots[j].px) +
                       sum_sq(list_slots[i].py, list_slots[j].py) +
                       sum_sq(list_slots[i].pz, list_slots[j].pz);
                // Negative squared mass always counts as below the threshold
                if (p_sq > e_sq || (e_sq - p_sq) < thresh_sq) begin
                  keep_vec[i] = 1'b0;
                  keep_vec[j] = 1'b0;
                end
              end
            end
          end
          for (int i = 0; i < list_len; i++) begin
            flag_want.keep       = keep_vec[i];
            flag_want.position   = POS_W'(i);
            flag_want.overflow   = list_overflow;
            flag_want.final_flag = (i == list_len - 1);
            flags_due.insert(flags_due.size(), flag_want);
          end
          list_len      = 0;
          list_overflow = 1'b0;
        end
      end

      // Compare each output transaction with the oldest expected flag
      if (out_ch.valid && out_ch.ready) begin
        flag_got = '{out_ch.keep, out_ch.position, out_ch.overflow, out_ch.final_flag};
        if (flags_due.size() == 0) begin
          log_mismatch($sformatf("unexpected flag keep=%0b pos=%0d ovf=%0b final=%0b",
                                 flag_got.keep, flag_got.position, flag_got.overflow,
                                 flag_got.final_flag));
        end else begin
          flag_want = flags_due.pop_front();
          if (flag_got !== flag_want) begin
            log_mismatch($sformatf({"flag mismatch: expected keep=%0b pos=%0d ovf=%0b ",
                                    "final=%0b, got keep=%0b pos=%0d ovf=%0b final=%0b"},
                                   flag_want.keep, flag_want.position, flag_want.overflow,
                                   flag_want.final_flag, flag_got.keep, flag_got.position,
                                   flag_got.overflow, flag_got.final_flag));
          end
        end
      end
    end
    flags_pending <= flags_due.size();
  end

endmodule

FILE: test/opposite_charge_pair_mass_veto_core_tb.sv
// Testbench top for the pair mass veto: clock, reset, particle lists, threshold phases, verdict.
`timescale 1ns / 1ps

module opposite_charge_pair_mass_veto_core_tb;

  localparam int MB                = ocpmv_pkg::MOMENTUM_BITS_DEF;
  localparam int CHARGE_W          = ocpmv_pkg::CHARGE_W;
  localparam int ENERGY_W          = ocpmv_pkg::ENERGY_W;
  localparam int THRESH_W          = ocpmv_pkg::THRESH_W;
  localparam int MAX_PARTICLES_DEF = ocpmv_pkg::MAX_PARTICLES_DEF;
  localparam logic [THRESH_W-1:0] THRESH_RESET = ocpmv_pkg::THRESH_RESET;
  localparam int PHASE_QTY = 14;
  localparam logic signed [MB-1:0] MOM_MAX = {1'b0, {(MB-1){1'b1}}};
  localparam logic signed [MB-1:0] MOM_MIN = {1'b1, {(MB-1){1'b0}}};
  localparam logic signed [CHARGE_W-1:0] Q_POS  = 2'sb01;
  localparam logic signed [CHARGE_W-1:0] Q_NEG  = 2'sb11;
  localparam logic signed [CHARGE_W-1:0] Q_NONE = 2'sb00;
  localparam logic signed [CHARGE_W-1:0] Q_NEG2 = 2'sb10;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [THRESH_W-1:0] cfg_wr_data;
  int                  mismatch_count;
  int                  flags_pending;

  logic [THRESH_W-1:0] cur_threshold = THRESH_RESET;
  bit                  no_gaps;
  bit                  hold_output;
  bit                  hold_done;
  int                  phase_items;
  int                  gap;

  ocpmv_in_if #(.MOMENTUM_BITS(MB)) in_ch ();
  ocpmv_out_if                      out_ch ();

  opposite_charge_pair_mass_veto_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ocpmv_keep_flag_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .flags_pending  (flags_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, some long ones, none during a burst
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one particle and hold it until the transaction completes
  task automatic send_particle(logic signed [CHARGE_W-1:0] q, logic [ENERGY_W-1:0] e,
                               logic signed [MB-1:0] x, logic signed [MB-1:0] y,
                               logic signed [MB-1:0] z, logic last);
    int g;
    in_ch.valid        <= 1'b1;
    in_ch.charge_sign  <= q;
    in_ch.energy       <= e;
    in_ch.mom_x        <= x;
    in_ch.mom_y        <= y;
    in_ch.mom_z        <= z;
    in_ch.last_in_list <= last;
    do @(posedge clk); while (!in_ch.ready);
    g = idle_cycles();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Send a list of random particles scaled around the current threshold
  task automatic send_random_list(int len);
    int                          mode, v, scale;
    logic signed [CHARGE_W-1:0]  q;
    logic        [ENERGY_W-1:0]  e;
    logic signed [MB-1:0]        m [3];
    scale   = (cur_threshold == 0) ? 1000 :
              (cur_threshold > 4000000) ? 4000000 : int'(cur_threshold);
    no_gaps = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      mode = $urandom_range(0, 9);
      if ($urandom_range(0, 7) == 0) begin
        q = CHARGE_W'($urandom);
      end else begin
        q = $urandom_range(0, 1) ? Q_POS : Q_NEG;
      end
      if (mode == 0) begin
        // Raw bit patterns over the full field widths
        e = ENERGY_W'($urandom);
        foreach (m[k]) m[k] = MB'($urandom);
      end else if (mode == 1) begin
        e = $urandom_range(0, 1) ? '1 : '0;
        foreach (m[k]) begin
          case ($urandom_range(0, 2))
            0:       m[k] = MOM_MIN;
            1:       m[k] = MOM_MAX;
            default: m[k] = '0;
          endcase
        end
      end else begin
        // Values near the threshold so pair masses straddle it
        e = ENERGY_W'($urandom_range(0, scale));
        foreach (m[k]) begin
          v    = int'($urandom_range(0, scale)) - scale / 2;
          m[k] = MB'(v);
        end
      end
      send_particle(q, e, m[0], m[1], m[2], i == len - 1);
    end
    phase_items += (len > MAX_PARTICLES_DEF) ? MAX_PARTICLES_DEF : len;
  endtask

  // Drain all flags, let the block settle, then write a new threshold
  task automatic write_threshold(logic [THRESH_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (flags_pending == 0);
    repeat (20) @(posedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_wr_data   <= value;
    cur_threshold  = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: random ready with one long hold-off when requested
  initial begin
    forever begin
      if (hold_output && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        gap = idle_cycles();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.charge_sign  <= '0;
    in_ch.energy       <= '0;
    in_ch.mom_x        <= '0;
    in_ch.mom_y        <= '0;
    in_ch.mom_z        <= '0;
    in_ch.last_in_list <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lists at the reset threshold
    // single particle list
    send_particle(Q_POS, 24'd5000, '0, '0, '0, 1'b1);
    // opposite charges at zero mass: both dropped
    send_particle(Q_POS, 24'd0, '0, '0, '0, 1'b0);
    send_particle(Q_NEG, 24'd0, '0, '0, '0, 1'b1);
    // same charge at low mass: both kept
    send_particle(Q_POS, 24'd100, '0, '0, '0, 1'b0);
    send_particle(Q_POS, 24'd100, '0, '0, '0, 1'b1);
    // neutral never pairs
    send_particle(Q_NONE, 24'd100, '0, '0, '0, 1'b0);
    send_particle(Q_NEG, 24'd100, '0, '0, '0, 1'b1);
    // charge pattern 10 reads as negative
    send_particle(Q_NEG2, 24'd100, '0, '0, '0, 1'b0);
    send_particle(Q_POS, 24'd100, '0, '0, '0, 1'b1);
    // momentum beyond energy: negative squared mass
    send_particle(Q_POS, 24'd10, MOM_MAX, '0, '0, 1'b0);
    send_particle(Q_NEG, 24'd10, MOM_MAX, MOM_MIN, MOM_MAX, 1'b1);
    // full-scale energies and opposing extreme momenta: heavy pair kept
    send_particle(Q_NEG, '1, MOM_MIN, MOM_MAX, MOM_MIN, 1'b0);
    send_particle(Q_POS, '1, MOM_MAX, MOM_MIN, MOM_MAX, 1'b1);
    // mass exactly at threshold is kept
    send_particle(Q_POS, 24'd6000, '0, '0, '0, 1'b0);
    send_particle(Q_NEG, 24'd6000, '0, '0, '0, 1'b1);
    // one MeV below threshold is dropped
    send_particle(Q_POS, 24'd5999, '0, '0, '0, 1'b0);
    send_particle(Q_NEG, 24'd6000, '0, '0, '0, 1'b1);
    // three particles, only the first pair vetoed
    send_particle(Q_POS, 24'd100, '0, '0, '0, 1'b0);
    send_particle(Q_NEG, 24'd100, '0, '0, '0, 1'b0);
    send_particle(Q_POS, 24'd50000, '0, '0, '0, 1'b1);

    // Random phases, one threshold setting each
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       write_threshold('0);
        1:       write_threshold('1);
        2:       write_threshold(THRESH_W'($urandom_range(1000, 60000)));
        3:       write_threshold(THRESH_W'(1));
        default: write_threshold(THRESH_W'($urandom));
      endcase
      phase_items = 0;
      if (ph == 0) send_random_list(18);
      if (ph == 1) hold_output = 1'b1;
      if (ph == 2) send_random_list(MAX_PARTICLES_DEF);
      while (phase_items < PHASE_QTY) begin
        case ($urandom_range(0, 99)) inside
          [0:59]:  send_random_list($urandom_range(1, 4));
          [60:84]: send_random_list($urandom_range(5, 10));
          [85:92]: send_random_list(MAX_PARTICLES_DEF);
          default: send_random_list($urandom_range(17, 19));
        endcase
      end
    end

    // Drain and give the verdict
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (flags_pending == 0);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && flags_pending == 0) begin
      $display("PASS opposite_charge_pair_mass_veto_core");
    end else begin
      $display("FAIL opposite_charge_pair_mass_veto_core");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("FAIL opposite_charge_pair_mass_veto_core");
    $finish;
  end

endmodule
